FILE: src/wgs_pkg.sv
// Shared types, constants and the sigmoid table of the windowed gate sigmoid layer.
package wgs_pkg;

  localparam int MAX_GATES_DEF       = 8;
  localparam int MAX_FEATURES_DEF    = 16;
  localparam int MAX_WINDOW_HALF_DEF = 1;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Input item operation codes.
  localparam logic [1:0] FUNC_WR_WEIGHT  = 2'd0;
  localparam logic [1:0] FUNC_WR_FEATURE = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE    = 2'd2;

  // Configuration register indexes (paddr[3:2]).
  localparam logic [1:0] REG_WINDOW_HALF  = 2'd0;
  localparam logic [1:0] REG_NUM_FEATURES = 2'd1;
  localparam logic [1:0] REG_NUM_GATES    = 2'd2;

  localparam logic       WH_RST = 1'b1;
  localparam logic [4:0] NF_RST = 5'd16;
  localparam logic [3:0] NG_RST = 4'd8;

  localparam logic [63:0] EXP_STEP = 64'd4034748383;

  typedef struct packed {
    logic [1:0]         func;
    logic [2:0]         gate_index;
    logic [1:0]         slot_index;
    logic [3:0]         feature_index;
    logic               is_bias;
    logic signed [15:0] data_value;
    logic [2:0]         slot_valid_mask;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_gate;
    logic [15:0] gate_value;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic issue;
    logic bias;
    logic acc_clr;
  } mac_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } seq_state_t;

  typedef logic [255:0][15:0] sig_rom_t;

  // Shift-and-subtract division, evaluated only while the table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry i stands for x = (i-128)/16; d walks e^(-k/16) in Q32.
  function automatic sig_rom_t build_sig_rom();
    logic [63:0]  d;
    logic [63:0]  den;
    logic [63:0]  v;
    logic [127:0] p;
    sig_rom_t     t;
    t = '0;
    d = 64'h1_0000_0000;
    for (int k = 0; k <= 128; k++) begin
      den = 64'h1_0000_0000 + d;
      if (k <= 127) begin
        v = udiv64(64'h1_0000_0000_0000 + (den >> 1), den);
        t[128 + k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      end
      if (k >= 1) begin
        v = udiv64((d << 16) + (den >> 1), den);
        t[128 - k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      end
      p = {64'd0, d} * {64'd0, EXP_STEP} + 128'h8000_0000;
      d = p[95:32];
    end
    return t;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

FILE: src/wgs_cfg.sv
// Configuration register file with the APB-style port and the clamped register values.
module wgs_cfg #(
  parameter int MAX_GATES       = wgs_pkg::MAX_GATES_DEF,
  parameter int MAX_FEATURES    = wgs_pkg::MAX_FEATURES_DEF,
  parameter int MAX_WINDOW_HALF = wgs_pkg::MAX_WINDOW_HALF_DEF,
  localparam int NF_W   = $clog2(MAX_FEATURES + 1),
  localparam int GCNT_W = $clog2(MAX_GATES + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [wgs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [wgs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [wgs_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output logic                           wh_eff,
  output logic [NF_W-1:0]                nf_eff,
  output logic [GCNT_W-1:0]              ng_eff
);

  logic       wh_r;
  logic [4:0] nf_r;
  logic [3:0] ng_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wh_r <= wgs_pkg::WH_RST;
      nf_r <= wgs_pkg::NF_RST;
      ng_r <= wgs_pkg::NG_RST;
    end else if (wr_en) begin
      case (reg_idx)
        wgs_pkg::REG_WINDOW_HALF:  wh_r <= cfg_pwdata[0];
        wgs_pkg::REG_NUM_FEATURES: nf_r <= cfg_pwdata[4:0];
        wgs_pkg::REG_NUM_GATES:    ng_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      wgs_pkg::REG_WINDOW_HALF:  cfg_prdata = {31'd0, wh_r};
      wgs_pkg::REG_NUM_FEATURES: cfg_prdata = {27'd0, nf_r};
      wgs_pkg::REG_NUM_GATES:    cfg_prdata = {28'd0, ng_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  // Register values beyond the built sizes saturate to those sizes.
  assign wh_eff = (MAX_WINDOW_HALF == 0) ? 1'b0 : wh_r;
  assign nf_eff = NF_W'((32'(nf_r) > MAX_FEATURES) ? MAX_FEATURES : 32'(nf_r));
  assign ng_eff = GCNT_W'((32'(ng_r) > MAX_GATES) ? MAX_GATES : 32'(ng_r));

endmodule

FILE: src/wgs_dp.sv
// Datapath: weight and feature stores, the shared multiply-accumulate and the sigmoid lookup.
module wgs_dp #(
  parameter int MAX_GATES       = wgs_pkg::MAX_GATES_DEF,
  parameter int MAX_FEATURES    = wgs_pkg::MAX_FEATURES_DEF,
  parameter int MAX_WINDOW_HALF = wgs_pkg::MAX_WINDOW_HALF_DEF,
  localparam int SLOTS    = 2 * MAX_WINDOW_HALF + 1,
  localparam int STRIDE   = MAX_FEATURES * SLOTS + 1,
  localparam int BIAS_OFS = MAX_FEATURES * SLOTS,
  localparam int WDEPTH   = MAX_GATES * STRIDE,
  localparam int FDEPTH   = SLOTS * MAX_FEATURES,
  localparam int WADDR_W  = $clog2(WDEPTH),
  localparam int FADDR_W  = (FDEPTH > 1) ? $clog2(FDEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_acc,
  input  wgs_pkg::in_item_t in_item,
  input  wgs_pkg::mac_ctl_t ctl,
  input  logic [WADDR_W-1:0] waddr,
  input  logic [FADDR_W-1:0] faddr,
  output logic              acc_done,
  output logic [15:0]       sig_value
);

  logic [15:0] wmem [WDEPTH];
  logic [15:0] fmem [FDEPTH];

  logic               wr_w;
  logic               wr_f;
  logic               addr_ok;
  logic [WADDR_W-1:0] wr_waddr;
  logic [FADDR_W-1:0] wr_faddr;

  logic signed [15:0] wq_r;
  logic signed [15:0] fq_r;
  logic               v1_r;
  logic               b1_r;
  logic signed [31:0] prod_nxt;
  logic signed [31:0] prod_r;
  logic               v2_r;
  logic               b2_r;
  logic        [40:0] sum;
  logic        [39:0] acc_nxt;
  logic        [39:0] acc_r;
  logic               done_r;
  logic signed [19:0] acc_hi;
  logic        [7:0]  idx;

  assign addr_ok = (32'(in_item.slot_index) < SLOTS) && (32'(in_item.feature_index) < MAX_FEATURES);

  assign wr_w = in_acc && (in_item.func == wgs_pkg::FUNC_WR_WEIGHT)
             && (32'(in_item.gate_index) < MAX_GATES) && (in_item.is_bias || addr_ok);
  assign wr_f = in_acc && (in_item.func == wgs_pkg::FUNC_WR_FEATURE) && addr_ok;

  assign wr_waddr = in_item.is_bias
    ? WADDR_W'(32'(in_item.gate_index) * STRIDE + BIAS_OFS)
    : WADDR_W'(32'(in_item.gate_index) * STRIDE + 32'(in_item.slot_index) * MAX_FEATURES
               + 32'(in_item.feature_index));
  assign wr_faddr = FADDR_W'(32'(in_item.slot_index) * MAX_FEATURES + 32'(in_item.feature_index));

  always_ff @(posedge clk) begin
    if (wr_w) begin
      wmem[wr_waddr] <= in_item.data_value;
    end
    if (ctl.issue) begin
      wq_r <= wmem[waddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_f) begin
      fmem[wr_faddr] <= in_item.data_value;
    end
    if (ctl.issue) begin
      fq_r <= fmem[faddr];
    end
  end

  // The bias rides the same product register, scaled up to Q8.24.
  always_comb begin
    if (b1_r) begin
      prod_nxt = {{4{wq_r[15]}}, wq_r, 12'd0};
    end else begin
      prod_nxt = fq_r * wq_r;
    end
  end

  assign sum = {acc_r[39], acc_r} + {{9{prod_r[31]}}, prod_r};

  always_comb begin
    case (sum[40:39])
      2'b01:   acc_nxt = {1'b0, {39{1'b1}}};
      2'b10:   acc_nxt = {1'b1, 39'd0};
      default: acc_nxt = sum[39:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      b1_r   <= 1'b0;
      v2_r   <= 1'b0;
      b2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= ctl.issue;
      b1_r   <= ctl.issue && ctl.bias;
      v2_r   <= v1_r;
      b2_r   <= b1_r;
      done_r <= v2_r && b2_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_done = done_r;

  // Table index is floor(sum*16)+128, clamped to the table.
  assign acc_hi = acc_r[39:20];

  always_comb begin
    if (acc_hi < -20'sd128) begin
      idx = 8'd0;
    end else if (acc_hi > 20'sd127) begin
      idx = 8'd255;
    end else begin
      idx = {~acc_r[27], acc_r[26:20]};
    end
  end

  assign sig_value = wgs_pkg::SIG_ROM[idx];

endmodule

FILE: src/wgs_seq.sv
// Sequencer: walks gates, slots and features for the shared MAC and holds the result register.
module wgs_seq #(
  parameter int MAX_GATES       = wgs_pkg::MAX_GATES_DEF,
  parameter int MAX_FEATURES    = wgs_pkg::MAX_FEATURES_DEF,
  parameter int MAX_WINDOW_HALF = wgs_pkg::MAX_WINDOW_HALF_DEF,
  localparam int SLOTS    = 2 * MAX_WINDOW_HALF + 1,
  localparam int STRIDE   = MAX_FEATURES * SLOTS + 1,
  localparam int BIAS_OFS = MAX_FEATURES * SLOTS,
  localparam int WDEPTH   = MAX_GATES * STRIDE,
  localparam int FDEPTH   = SLOTS * MAX_FEATURES,
  localparam int WADDR_W  = $clog2(WDEPTH),
  localparam int FADDR_W  = (FDEPTH > 1) ? $clog2(FDEPTH) : 1,
  localparam int NF_W     = $clog2(MAX_FEATURES + 1),
  localparam int GCNT_W   = $clog2(MAX_GATES + 1),
  localparam int GIDX_W   = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1,
  localparam int FIDX_W   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
  localparam int SCNT_W   = $clog2(SLOTS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wgs_pkg::in_item_t  in_item,
  output logic               in_acc,
  output logic               out_valid,
  input  logic               out_stall,
  output wgs_pkg::out_item_t out_item,
  input  logic               wh_eff,
  input  logic [NF_W-1:0]    nf_eff,
  input  logic [GCNT_W-1:0]  ng_eff,
  output wgs_pkg::mac_ctl_t  ctl,
  output logic [WADDR_W-1:0] waddr,
  output logic [FADDR_W-1:0] faddr,
  input  logic               acc_done,
  input  logic [15:0]        sig_value
);

  wgs_pkg::seq_state_t state_r, state_nxt;
  logic [GIDX_W-1:0]   g_r, g_nxt;
  logic [SCNT_W-1:0]   s_r, s_nxt;
  logic [FIDX_W-1:0]   f_r, f_nxt;
  logic [2:0]          mask_r, mask_nxt;
  logic [NF_W-1:0]     nf_r, nf_nxt;
  logic [GCNT_W-1:0]   ng_r, ng_nxt;
  logic [SCNT_W-1:0]   lo_r, lo_nxt;
  logic [SCNT_W-1:0]   hi_r, hi_nxt;
  logic                out_valid_r, out_valid_nxt;
  wgs_pkg::out_item_t  out_item_r, out_item_nxt;

  logic [2:0]  mask_sh;
  logic        slot_on;
  logic        f_last;
  logic        g_last;
  logic        out_free;
  logic [SCNT_W-1:0] lo_new;

  assign in_stall  = (state_r != wgs_pkg::ST_IDLE);
  assign in_acc    = in_valid && (state_r == wgs_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign mask_sh = mask_r >> s_r;
  assign slot_on = mask_sh[0] && (nf_r != '0);
  assign f_last  = ((NF_W'(f_r) + NF_W'(1)) == nf_r);
  assign g_last  = ((GCNT_W'(g_r) + GCNT_W'(1)) == ng_r);
  assign out_free = !out_valid_r || !out_stall;
  assign lo_new  = SCNT_W'(MAX_WINDOW_HALF) - SCNT_W'(wh_eff);

  assign faddr = FADDR_W'(32'(s_r) * MAX_FEATURES + 32'(f_r));

  always_comb begin
    state_nxt     = state_r;
    g_nxt         = g_r;
    s_nxt         = s_r;
    f_nxt         = f_r;
    mask_nxt      = mask_r;
    nf_nxt        = nf_r;
    ng_nxt        = ng_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    ctl           = '0;
    waddr         = WADDR_W'(32'(g_r) * STRIDE + 32'(s_r) * MAX_FEATURES + 32'(f_r));

    case (state_r)
      wgs_pkg::ST_IDLE: begin
        if (in_valid && (in_item.func == wgs_pkg::FUNC_COMPUTE) && (ng_eff != '0)) begin
          mask_nxt    = in_item.slot_valid_mask;
          nf_nxt      = nf_eff;
          ng_nxt      = ng_eff;
          lo_nxt      = lo_new;
          hi_nxt      = SCNT_W'(MAX_WINDOW_HALF) + SCNT_W'(wh_eff);
          g_nxt       = '0;
          s_nxt       = lo_new;
          f_nxt       = '0;
          ctl.acc_clr = 1'b1;
          state_nxt   = wgs_pkg::ST_ISSUE;
        end
      end
      wgs_pkg::ST_ISSUE: begin
        if (s_r <= hi_r) begin
          // A slot outside the sequence advances the slot without an issue.
          if (slot_on) begin
            ctl.issue = 1'b1;
            if (f_last) begin
              f_nxt = '0;
              s_nxt = s_r + SCNT_W'(1);
            end else begin
              f_nxt = f_r + FIDX_W'(1);
            end
          end else begin
            s_nxt = s_r + SCNT_W'(1);
          end
        end else begin
          ctl.issue = 1'b1;
          ctl.bias  = 1'b1;
          waddr     = WADDR_W'(32'(g_r) * STRIDE + BIAS_OFS);
          state_nxt = wgs_pkg::ST_DRAIN;
        end
      end
      wgs_pkg::ST_DRAIN: begin
        if (acc_done) begin
          state_nxt = wgs_pkg::ST_EMIT;
        end
      end
      wgs_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.out_gate   = 3'(g_r);
          out_item_nxt.gate_value = sig_value;
          out_item_nxt.last       = g_last;
          if (g_last) begin
            state_nxt = wgs_pkg::ST_IDLE;
          end else begin
            g_nxt       = g_r + GIDX_W'(1);
            s_nxt       = lo_r;
            f_nxt       = '0;
            ctl.acc_clr = 1'b1;
            state_nxt   = wgs_pkg::ST_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = wgs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wgs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    g_r        <= g_nxt;
    s_r        <= s_nxt;
    f_r        <= f_nxt;
    mask_r     <= mask_nxt;
    nf_r       <= nf_nxt;
    ng_r       <= ng_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

FILE: src/windowed_gate_sigmoid_layer.sv
// Top level of the windowed gate sigmoid layer: configuration, sequencer and datapath.
//
//   channel | direction | handshake                  | payload
//   in_     | input     | in_valid / in_stall        | in_item  (wgs_pkg::in_item_t)
//   out_    | output    | out_valid / out_stall      | out_item (wgs_pkg::out_item_t)
//   cfg_    | input     | cfg_psel / cfg_penable     | cfg_paddr, cfg_pwdata, cfg_prdata
//
// A compute item runs all its multiply-accumulates through one shared multiplier and
// accumulator, one per cycle: per gate, nf of them for each slot lo..hi that is in
// the sequence when nf is nonzero, followed by the bias issue, the pipeline drain and
// the result.
// Reset clears control state and the configuration registers; the stores keep no reset.
// While a compute runs, in_stall is high; a stalled result holds the gate walk in place.
module windowed_gate_sigmoid_layer #(
  parameter int MAX_GATES       = wgs_pkg::MAX_GATES_DEF,
  parameter int MAX_FEATURES    = wgs_pkg::MAX_FEATURES_DEF,
  parameter int MAX_WINDOW_HALF = wgs_pkg::MAX_WINDOW_HALF_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  wgs_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output wgs_pkg::out_item_t             out_item,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [wgs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [wgs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [wgs_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int SLOTS   = 2 * MAX_WINDOW_HALF + 1;
  localparam int STRIDE  = MAX_FEATURES * SLOTS + 1;
  localparam int WDEPTH  = MAX_GATES * STRIDE;
  localparam int FDEPTH  = SLOTS * MAX_FEATURES;
  localparam int WADDR_W = $clog2(WDEPTH);
  localparam int FADDR_W = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
  localparam int NF_W    = $clog2(MAX_FEATURES + 1);
  localparam int GCNT_W  = $clog2(MAX_GATES + 1);

  logic               wh_eff;
  logic [NF_W-1:0]    nf_eff;
  logic [GCNT_W-1:0]  ng_eff;
  logic               in_acc;
  wgs_pkg::mac_ctl_t  ctl;
  logic [WADDR_W-1:0] waddr;
  logic [FADDR_W-1:0] faddr;
  logic               acc_done;
  logic [15:0]        sig_value;

  wgs_cfg #(
    .MAX_GATES       (MAX_GATES),
    .MAX_FEATURES    (MAX_FEATURES),
    .MAX_WINDOW_HALF (MAX_WINDOW_HALF)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .wh_eff      (wh_eff),
    .nf_eff      (nf_eff),
    .ng_eff      (ng_eff)
  );

  wgs_dp #(
    .MAX_GATES       (MAX_GATES),
    .MAX_FEATURES    (MAX_FEATURES),
    .MAX_WINDOW_HALF (MAX_WINDOW_HALF)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_item   (in_item),
    .ctl       (ctl),
    .waddr     (waddr),
    .faddr     (faddr),
    .acc_done  (acc_done),
    .sig_value (sig_value)
  );

  wgs_seq #(
    .MAX_GATES       (MAX_GATES),
    .MAX_FEATURES    (MAX_FEATURES),
    .MAX_WINDOW_HALF (MAX_WINDOW_HALF)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .in_acc    (in_acc),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .wh_eff    (wh_eff),
    .nf_eff    (nf_eff),
    .ng_eff    (ng_eff),
    .ctl       (ctl),
    .waddr     (waddr),
    .faddr     (faddr),
    .acc_done  (acc_done),
    .sig_value (sig_value)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the windowed gate sigmoid layer with its own gate predictor.
class gate_scoreboard;
  localparam int NUM_GATES    = 8;
  localparam int NUM_FEAT     = 16;
  localparam int WIN_MAX      = 1;
  localparam int NUM_SLOTS    = 2 * WIN_MAX + 1;
  localparam int GATE_STRIDE  = NUM_FEAT * NUM_SLOTS + 1;
  localparam int BIAS_OFFSET  = NUM_FEAT * NUM_SLOTS;
  localparam longint ACC_TOP  = 64'sd549755813887;
  localparam bit [63:0] DECAY = 64'd4034748383;

  bit [15:0] weight_mem [NUM_GATES * GATE_STRIDE];
  bit [15:0] feature_mem [NUM_SLOTS * NUM_FEAT];
  bit [15:0] sigmoid_lut [256];
  bit        win_half;
  bit [4:0]  feat_used;
  bit [3:0]  gates_used;
  wgs_pkg::out_item_t gate_results_due [$];
  int        errors;

  function new();
    bit [63:0] d;
    bit [63:0] den;
    bit [63:0] v;
    win_half   = 1'b1;
    feat_used  = 5'd16;
    gates_used = 4'd8;
    errors     = 0;
    // d walks e^(-k/16) in Q32; both halves of the table are built from it.
    d = 64'h1_0000_0000;
    for (int k = 0; k <= 128; k++) begin
      den = 64'h1_0000_0000 + d;
      if (k <= 127) begin
        v = ((64'd1 << 48) + den / 2) / den;
        sigmoid_lut[128 + k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      end
      if (k >= 1) begin
        v = ((d << 16) + den / 2) / den;
        sigmoid_lut[128 - k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      end
      d = (d * DECAY + 64'h8000_0000) >> 32;
    end
  endfunction

  task report(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function void write_reg(logic [1:0] idx, logic [31:0] value);
    case (idx)
      wgs_pkg::REG_WINDOW_HALF:  win_half   = value[0];
      wgs_pkg::REG_NUM_FEATURES: feat_used  = value[4:0];
      wgs_pkg::REG_NUM_GATES:    gates_used = value[3:0];
      default: ;
    endcase
  endfunction

  function longint clamp_acc(longint v);
    if (v > ACC_TOP) return ACC_TOP;
    if (v < -ACC_TOP - 1) return -ACC_TOP - 1;
    return v;
  endfunction

  function void predict_gates(logic [2:0] mask);
    int        nfe;
    int        nga;
    longint    acc;
    longint    x;
    longint    w;
    longint    idx;
    wgs_pkg::out_item_t r;
    nfe = (feat_used > NUM_FEAT) ? NUM_FEAT : feat_used;
    nga = (gates_used > NUM_GATES) ? NUM_GATES : gates_used;
    for (int g = 0; g < nga; g++) begin
      acc = 0;
      for (int s = WIN_MAX - win_half; s <= WIN_MAX + win_half; s++) begin
        if (mask[s]) begin
          for (int f = 0; f < nfe; f++) begin
            x = $signed(feature_mem[s * NUM_FEAT + f]);
            w = $signed(weight_mem[g * GATE_STRIDE + s * NUM_FEAT + f]);
            acc = clamp_acc(acc + x * w);
          end
        end
      end
      w = $signed(weight_mem[g * GATE_STRIDE + BIAS_OFFSET]);
      acc = clamp_acc(acc + w * 4096);
      // Sum is Q16.24; the table steps by 1/16.
      idx = (acc >>> 20) + 128;
      if (idx < 0) idx = 0;
      if (idx > 255) idx = 255;
      r.out_gate   = g[2:0];
      r.gate_value = sigmoid_lut[idx];
      r.last       = (g + 1 == nga);
      gate_results_due.push_back(r);
    end
  endfunction

  function void note_item(wgs_pkg::in_item_t it);
    int g;
    int s;
    int f;
    g = it.gate_index;
    s = it.slot_index;
    f = it.feature_index;
    case (it.func)
      wgs_pkg::FUNC_WR_WEIGHT: begin
        if (it.is_bias) weight_mem[g * GATE_STRIDE + BIAS_OFFSET] = it.data_value;
        else if (s < NUM_SLOTS) weight_mem[g * GATE_STRIDE + s * NUM_FEAT + f] = it.data_value;
      end
      wgs_pkg::FUNC_WR_FEATURE: begin
        if (s < NUM_SLOTS) feature_mem[s * NUM_FEAT + f] = it.data_value;
      end
      wgs_pkg::FUNC_COMPUTE: predict_gates(it.slot_valid_mask);
      default: ;
    endcase
  endfunction

  task check_gate(wgs_pkg::out_item_t got);
    wgs_pkg::out_item_t want;
    if (gate_results_due.size() == 0) begin
      report($sformatf("result with none due: gate %0d value %h last %b",
                       got.out_gate, got.gate_value, got.last));
      return;
    end
    want = gate_results_due.pop_front();
    if (got.out_gate !== want.out_gate)
      report($sformatf("out_gate %0d, want %0d", got.out_gate, want.out_gate));
    if (got.gate_value !== want.gate_value)
      report($sformatf("gate %0d value %h, want %h", want.out_gate, got.gate_value,
                       want.gate_value));
    if (got.last !== want.last)
      report($sformatf("gate %0d last %b, want %b", want.out_gate, got.last, want.last));
  endtask

  task check_drained();
    if (gate_results_due.size() != 0)
      report($sformatf("%0d results never arrived", gate_results_due.size()));
  endtask
endclass

module testbench;
  localparam int         CYCLE_LIMIT = 5_000_000;
  localparam int         QUIET_WAIT  = 500;
  localparam logic [1:0] FUNC_SPARE  = 2'd3;
  localparam logic [1:0] REG_SPARE   = 2'd3;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  wgs_pkg::in_item_t     in_item     = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  wgs_pkg::out_item_t    out_item;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [wgs_pkg::CFG_ADDR_W-1:0] cfg_paddr  = '0;
  logic [wgs_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [wgs_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int             in_idle_pct   = 0;
  int             out_stall_pct = 0;
  int             cycle_count   = 0;
  gate_scoreboard sb;

  windowed_gate_sigmoid_layer u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) sb.check_gate(out_item);
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  function automatic wgs_pkg::in_item_t make_item(logic [1:0] func, logic [2:0] gate,
                                                  logic [1:0] slot, logic [3:0] feat,
                                                  logic bias, logic [15:0] data,
                                                  logic [2:0] mask);
    wgs_pkg::in_item_t it;
    it.func            = func;
    it.gate_index      = gate;
    it.slot_index      = slot;
    it.feature_index   = feat;
    it.is_bias         = bias;
    it.data_value      = data;
    it.slot_valid_mask = mask;
    return it;
  endfunction

  // Mix of extremes, full-range values and small values that keep sums inside the table.
  function automatic logic [15:0] q412_value();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    if (pick < 5) return 16'($urandom);
    return 16'($urandom_range(1023)) - 16'd512;
  endfunction

  function automatic wgs_pkg::in_item_t random_item();
    wgs_pkg::in_item_t it;
    int unsigned       pick;
    it = make_item(wgs_pkg::FUNC_COMPUTE, 3'($urandom_range(7)), 2'($urandom_range(2)),
                   4'($urandom_range(15)), ($urandom_range(99) < 15), q412_value(),
                   3'($urandom_range(7)));
    pick = $urandom_range(99);
    if (pick < 35) it.func = wgs_pkg::FUNC_WR_WEIGHT;
    else if (pick < 60) it.func = wgs_pkg::FUNC_WR_FEATURE;
    else if (pick < 92) it.func = wgs_pkg::FUNC_COMPUTE;
    else if (pick < 96) it.func = FUNC_SPARE;
    else begin
      // A write to a slot outside the window must be dropped.
      it.func       = $urandom_range(1) ? wgs_pkg::FUNC_WR_WEIGHT : wgs_pkg::FUNC_WR_FEATURE;
      it.slot_index = 2'd3;
      it.is_bias    = 1'b0;
    end
    return it;
  endfunction

  task send_item(wgs_pkg::in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_item(it);
  endtask

  task cfg_write(logic [1:0] idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.gate_results_due.size() != 0);
  endtask

  // A compute with no gates leaves nothing to wait for, so give it time to finish.
  task settle();
    wait_drained();
    repeat (QUIET_WAIT) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill both stores so that no compute ever reads an unwritten entry.
    for (int g = 0; g < 8; g++) begin
      for (int s = 0; s < 3; s++) begin
        for (int f = 0; f < 16; f++) begin
          send_item(make_item(wgs_pkg::FUNC_WR_WEIGHT, 3'(g), 2'(s), 4'(f), 1'b0,
                              q412_value(), 3'($urandom_range(7))));
        end
      end
      send_item(make_item(wgs_pkg::FUNC_WR_WEIGHT, 3'(g), 2'($urandom_range(3)),
                          4'($urandom_range(15)), 1'b1, q412_value(),
                          3'($urandom_range(7))));
    end
    for (int s = 0; s < 3; s++) begin
      for (int f = 0; f < 16; f++) begin
        send_item(make_item(wgs_pkg::FUNC_WR_FEATURE, 3'($urandom_range(7)), 2'(s), 4'(f),
                            1'($urandom_range(1)), q412_value(), 3'($urandom_range(7))));
      end
    end

    send_item(make_item(wgs_pkg::FUNC_WR_WEIGHT, 3'd7, 2'd2, 4'd15, 1'b0, 16'h7FFF, 3'd7));
    send_item(make_item(wgs_pkg::FUNC_WR_WEIGHT, 3'd0, 2'd0, 4'd0, 1'b0, 16'h8000, 3'd0));
    send_item(make_item(wgs_pkg::FUNC_WR_WEIGHT, 3'd7, 2'd3, 4'd15, 1'b1, 16'h7FFF, 3'd7));
    send_item(make_item(wgs_pkg::FUNC_WR_WEIGHT, 3'd0, 2'd0, 4'd0, 1'b1, 16'h8000, 3'd0));
    send_item(make_item(wgs_pkg::FUNC_WR_FEATURE, 3'd7, 2'd2, 4'd15, 1'b1, 16'h7FFF, 3'd7));
    send_item(make_item(wgs_pkg::FUNC_WR_FEATURE, 3'd0, 2'd0, 4'd0, 1'b0, 16'h8000, 3'd0));
    send_item(make_item(wgs_pkg::FUNC_WR_WEIGHT, 3'd3, 2'd3, 4'd5, 1'b0, 16'h1234, 3'd2));
    send_item(make_item(wgs_pkg::FUNC_WR_FEATURE, 3'd5, 2'd3, 4'd9, 1'b0, 16'hEDCB, 3'd5));
    send_item(make_item(FUNC_SPARE, 3'd7, 2'd3, 4'd15, 1'b1, 16'hFFFF, 3'd7));
    send_item(make_item(wgs_pkg::FUNC_COMPUTE, 3'd0, 2'd0, 4'd0, 1'b0, 16'h0000, 3'd7));
    send_item(make_item(wgs_pkg::FUNC_COMPUTE, 3'd7, 2'd3, 4'd15, 1'b1, 16'hFFFF, 3'd0));
    send_item(make_item(wgs_pkg::FUNC_COMPUTE, 3'd2, 2'd1, 4'd3, 1'b0, 16'h0400, 3'd5));
    send_item(make_item(wgs_pkg::FUNC_COMPUTE, 3'd5, 2'd2, 4'd12, 1'b1, 16'hFC00, 3'd2));

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0: cfg_write(REG_SPARE, $urandom);
        1: begin
          cfg_write(wgs_pkg::REG_WINDOW_HALF, 32'd0);
          cfg_write(wgs_pkg::REG_NUM_FEATURES, 32'd1);
          cfg_write(wgs_pkg::REG_NUM_GATES, 32'd1);
        end
        2: begin
          cfg_write(wgs_pkg::REG_WINDOW_HALF, 32'd1);
          cfg_write(wgs_pkg::REG_NUM_FEATURES, 32'd31);
          cfg_write(wgs_pkg::REG_NUM_GATES, 32'd15);
        end
        3: begin
          cfg_write(wgs_pkg::REG_WINDOW_HALF, 32'd0);
          cfg_write(wgs_pkg::REG_NUM_FEATURES, 32'd0);
          cfg_write(wgs_pkg::REG_NUM_GATES, 32'd3);
        end
        4: begin
          cfg_write(wgs_pkg::REG_WINDOW_HALF, 32'd1);
          cfg_write(wgs_pkg::REG_NUM_FEATURES, 32'd5);
          cfg_write(wgs_pkg::REG_NUM_GATES, 32'd0);
        end
        5: begin
          cfg_write(wgs_pkg::REG_NUM_FEATURES, 32'd17);
          cfg_write(wgs_pkg::REG_NUM_GATES, 32'd9);
        end
        6: begin
          cfg_write(wgs_pkg::REG_WINDOW_HALF, $urandom_range(1));
          cfg_write(wgs_pkg::REG_NUM_FEATURES, $urandom_range(6, 1));
          cfg_write(wgs_pkg::REG_NUM_GATES, $urandom_range(8, 1));
        end
        default: begin
          // Upper data bits beyond each register's width are dropped.
          cfg_write(wgs_pkg::REG_WINDOW_HALF, $urandom);
          cfg_write(wgs_pkg::REG_NUM_FEATURES, $urandom);
          cfg_write(wgs_pkg::REG_NUM_GATES, $urandom);
        end
      endcase
      case (phase % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 78; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 78; end
        default: begin in_idle_pct = 14; out_stall_pct = 14; end
      endcase
      for (int i = 0; i < 62; i++) begin
        if (i == 31 && phase % 4 == 1) wait_drained();
        send_item(random_item());
      end
    end

    settle();
    sb.check_drained();
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

FILE: filelist.f
src/wgs_pkg.sv
src/wgs_cfg.sv
src/wgs_dp.sv
src/wgs_seq.sv
src/windowed_gate_sigmoid_layer.sv
tb/testbench.sv
